// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ===== rtl/hrp_pkg.sv =====
`default_nettype none
package hrp_pkg;

   localparam int POS_BITS = 32;

   // parser phases
   localparam logic [3:0] PH_METHOD  = 4'd0;
   localparam logic [3:0] PH_PATH    = 4'd1;
   localparam logic [3:0] PH_VERSION = 4'd2;
   localparam logic [3:0] PH_NAME    = 4'd3;
   localparam logic [3:0] PH_VALUE   = 4'd4;
   localparam logic [3:0] PH_BODY    = 4'd5;
   localparam logic [3:0] PH_DONE    = 4'd6;
   localparam logic [3:0] PH_BAD     = 4'd7;
   localparam logic [3:0] PH_MANY    = 4'd8;
   localparam logic [3:0] PH_TE      = 4'd9;

   // status codes
   localparam logic [2:0] ST_MORE = 3'd0;
   localparam logic [2:0] ST_DONE = 3'd1;
   localparam logic [2:0] ST_BAD  = 3'd2;
   localparam logic [2:0] ST_MANY = 3'd3;
   localparam logic [2:0] ST_TE   = 3'd4;

   // slice kinds
   localparam logic [2:0] SK_NONE    = 3'd0;
   localparam logic [2:0] SK_METHOD  = 3'd1;
   localparam logic [2:0] SK_PATH    = 3'd2;
   localparam logic [2:0] SK_VERSION = 3'd3;
   localparam logic [2:0] SK_INM     = 3'd4;
   localparam logic [2:0] SK_IMS     = 3'd5;
   localparam logic [2:0] SK_BODY    = 3'd6;

   // register indexes
   localparam logic [7:0] REG_LINE_LIMIT  = 8'd0;
   localparam logic [7:0] REG_FIELD_LIMIT = 8'd1;
   localparam logic [7:0] REG_MAX_FIELDS  = 8'd2;

   localparam logic [15:0] LIMIT_RESET  = 16'd8192;
   localparam logic [7:0]  FIELDS_RESET = 8'd32;

   localparam logic [3:0] VER_BAD    = 4'd9;
   localparam logic [4:0] DIGIT_BAD  = 5'd31;
   localparam logic [4:0] MAX_DIGITS = 5'd20;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slice_kind;
      logic [31:0] slice_offset;
      logic [63:0] slice_length;
      logic [63:0] body_size;
      logic        persist_conn;
   } result_type;

   typedef struct packed {
      logic [15:0] line_limit;
      logic [15:0] field_limit;
      logic [7:0]  max_fields;
   } cfg_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic logic [4:0] name_len(input int k);
      case (k)
         0:       return 5'd14;
         1:       return 5'd10;
         2:       return 5'd13;
         3:       return 5'd17;
         default: return 5'd17;
      endcase
   endfunction

   // character i of known header name k (i below its length)
   function automatic logic [7:0] name_char(input int k, input logic [4:0] i);
      logic [135:0] s;
      logic [4:0]   p;
      case (k)
         0:       s = 136'("content-length");
         1:       s = 136'("connection");
         2:       s = 136'("if-none-match");
         3:       s = 136'("if-modified-since");
         default: s = 136'("transfer-encoding");
      endcase
      p = name_len(k) - 5'd1 - i;
      return s[8*p +: 8];
   endfunction

   function automatic logic [7:0] ver_char(input logic [2:0] i);
      logic [63:0] s;
      s = "http/1.1";
      return s[8*(3'd7 - i) +: 8];
   endfunction

   function automatic logic [7:0] ka_char(input logic [3:0] i);
      logic [79:0] s;
      s = "keep-alive";
      return s[8*(4'd9 - i) +: 8];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/hrp_channels.sv =====
`default_nettype none
interface hrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       new_request;
   modport source (output valid, data_byte, new_request, input ready);
   modport sink (input valid, data_byte, new_request, output ready);
endinterface

interface hrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [2:0]  slice_kind;
   logic [31:0] slice_offset;
   logic [63:0] slice_length;
   logic [63:0] body_size;
   logic        persist_conn;
   modport source (output valid, status, slice_kind, slice_offset, slice_length,
                   body_size, persist_conn, input ready);
   modport sink (input valid, status, slice_kind, slice_offset, slice_length,
                 body_size, persist_conn, output ready);
endinterface

interface hrp_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hrp_core.sv =====
`default_nettype none
module hrp_core
   import hrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] data_byte,
   input  wire logic       new_request,
   input  wire cfg_type    cfg,
   output result_type      result
);

   logic [3:0]          phase_ff, phase_in;
   logic                cr_ff, cr_in;
   logic [POS_BITS-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [7:0]          lines_ff, lines_in;
   logic [4:0]          match_ff, match_in, nidx_ff, nidx_in;
   logic                lead_ff, lead_in;
   logic [15:0]         trim_ff, trim_in;
   logic [63:0]         acc_ff, acc_in, blen_ff, blen_in, rem_ff, rem_in;
   logic [4:0]          digits_ff, digits_in;
   logic [3:0]          vflags_ff, vflags_in, ver_ff, ver_in;
   logic                lseen_ff, lseen_in, lerr_ff, lerr_in;
   logic                conn_ff, conn_in, persist_ff, persist_in, te_ff, te_in;

   // current state after an optional new-request clear
   logic [3:0]          phase_c, ver_c;
   logic                cr_c, lead_c, lseen_c, lerr_c, conn_c, persist_c, te_c;
   logic [POS_BITS-1:0] pos_c, start_c, span, pos_next;
   logic [7:0]          lines_c;
   logic [4:0]          match_c, nidx_c, digits_c;
   logic [15:0]         trim_c;
   logic [63:0]         acc_c, blen_c, rem_c;
   logic [3:0]          vflags_c;

   logic [7:0]  lc;
   logic        is_blank, gap;
   logic [67:0] acc_x10;
   logic [2:0]  kind;
   logic [31:0] soff;
   logic [63:0] slen;

   always_comb begin
      if (new_request) begin
         phase_c = PH_METHOD; cr_c = 1'b0; pos_c = '0; start_c = '0;
         lines_c = '0; match_c = 5'h1f; nidx_c = '0; lead_c = 1'b1;
         trim_c = '0; acc_c = '0; digits_c = '0; vflags_c = '0;
         lseen_c = 1'b0; lerr_c = 1'b0; blen_c = '0; conn_c = 1'b0;
         persist_c = 1'b0; te_c = 1'b0; ver_c = '0; rem_c = '0;
      end else begin
         phase_c = phase_ff; cr_c = cr_ff; pos_c = pos_ff; start_c = start_ff;
         lines_c = lines_ff; match_c = match_ff; nidx_c = nidx_ff; lead_c = lead_ff;
         trim_c = trim_ff; acc_c = acc_ff; digits_c = digits_ff; vflags_c = vflags_ff;
         lseen_c = lseen_ff; lerr_c = lerr_ff; blen_c = blen_ff; conn_c = conn_ff;
         persist_c = persist_ff; te_c = te_ff; ver_c = ver_ff; rem_c = rem_ff;
      end
   end

   assign span     = pos_c - start_c;
   assign pos_next = pos_c + 1'b1;
   assign lc       = to_lower(data_byte);
   assign is_blank = (data_byte == 8'h20) || (data_byte == 8'h09);
   assign gap      = span != POS_BITS'(trim_c);
   assign acc_x10  = {1'b0, acc_c, 3'b000} + {3'b000, acc_c, 1'b0} +
                     68'(data_byte - 8'h30);

   // per-byte state update
   always_comb begin
      phase_in = phase_c; cr_in = cr_c; start_in = start_c; lines_in = lines_c;
      match_in = match_c; nidx_in = nidx_c; lead_in = lead_c; trim_in = trim_c;
      acc_in = acc_c; digits_in = digits_c; vflags_in = vflags_c; lseen_in = lseen_c;
      lerr_in = lerr_c; blen_in = blen_c; conn_in = conn_c; persist_in = persist_c;
      te_in = te_c; ver_in = ver_c; rem_in = rem_c;
      pos_in = pos_next;
      kind = SK_NONE; soff = '0; slen = '0;

      if (cr_c) begin
         cr_in = 1'b0;
         if (data_byte != 8'h0a) begin
            phase_in = PH_BAD;
         end else if (phase_c == PH_VERSION) begin
            kind = SK_VERSION; soff = 32'(start_c); slen = 64'(span - 1'b1);
            start_in = pos_next; match_in = 5'h1f; nidx_in = '0; phase_in = PH_NAME;
         end else if (phase_c == PH_VALUE) begin
            if (vflags_c[0]) begin
               if (digits_c == 5'd0 || digits_c > MAX_DIGITS) lerr_in = 1'b1;
               else if (lseen_c && acc_c != blen_c) lerr_in = 1'b1;
               else begin
                  blen_in = acc_c; lseen_in = 1'b1;
               end
            end
            if (vflags_c[1]) begin
               conn_in = 1'b1;
               persist_in = match_c[0] && (trim_c == 16'd10);
            end
            if (vflags_c[2]) begin
               kind = SK_INM; soff = 32'(start_c); slen = 64'(trim_c);
            end
            if (vflags_c[3]) begin
               kind = SK_IMS; soff = 32'(start_c); slen = 64'(trim_c);
            end
            lines_in = lines_c + 8'd1;
            start_in = pos_next; match_in = 5'h1f; nidx_in = '0; phase_in = PH_NAME;
         end else if (phase_c == PH_NAME) begin
            if (!conn_c) persist_in = (ver_c == 4'd8);
            if (lerr_c) phase_in = PH_BAD;
            else if (te_c) phase_in = PH_TE;
            else if (blen_c != 64'd0) begin
               rem_in = blen_c; start_in = pos_next; phase_in = PH_BODY;
            end else phase_in = PH_DONE;
         end
      end else begin
         case (phase_c)
            PH_METHOD, PH_PATH: begin
               if (data_byte == 8'h20) begin
                  if (span == '0) phase_in = PH_BAD;
                  else begin
                     kind = (phase_c == PH_METHOD) ? SK_METHOD : SK_PATH;
                     soff = 32'(start_c); slen = 64'(span);
                     start_in = pos_next;
                     phase_in = (phase_c == PH_METHOD) ? PH_PATH : PH_VERSION;
                  end
               end else if (span >= POS_BITS'(cfg.line_limit)) phase_in = PH_BAD;
            end
            PH_VERSION: begin
               if (data_byte == 8'h0d) begin
                  if (span != POS_BITS'(8)) ver_in = VER_BAD;
                  cr_in = 1'b1;
               end else if (span >= POS_BITS'(cfg.line_limit)) begin
                  phase_in = PH_BAD;
               end else if (span < POS_BITS'(8) && POS_BITS'(ver_c) == span &&
                            lc == ver_char(span[2:0])) begin
                  ver_in = ver_c + 4'd1;
               end else ver_in = VER_BAD;
            end
            PH_NAME: begin
               if (data_byte == 8'h0d) begin
                  if (span != '0) phase_in = PH_BAD;
                  else cr_in = 1'b1;
               end else if (data_byte == 8'h3a) begin
                  if (lines_c >= cfg.max_fields) phase_in = PH_MANY;
                  else if (span == '0) phase_in = PH_BAD;
                  else begin
                     for (int k = 0; k < 5; k++)
                        if (nidx_c != name_len(k)) match_in[k] = 1'b0;
                     if (match_in[4]) te_in = 1'b1;
                     vflags_in = match_in[3:0];
                     match_in = 5'd1;
                     lead_in = 1'b1; trim_in = '0; acc_in = '0; digits_in = '0;
                     start_in = pos_next; phase_in = PH_VALUE;
                  end
               end else if (span >= POS_BITS'(cfg.field_limit)) phase_in = PH_BAD;
               else begin
                  for (int k = 0; k < 5; k++)
                     if (nidx_c >= name_len(k) || lc != name_char(k, nidx_c))
                        match_in[k] = 1'b0;
                  if (nidx_c < 5'd31) nidx_in = nidx_c + 5'd1;
               end
            end
            PH_VALUE: begin
               if (data_byte == 8'h0d) cr_in = 1'b1;
               else if (lead_c && is_blank) start_in = pos_next;
               else begin
                  lead_in = 1'b0;
                  if (span >= POS_BITS'(cfg.field_limit)) phase_in = PH_BAD;
                  else if (!is_blank) begin
                     if (gap || data_byte < 8'h30 || data_byte > 8'h39) digits_in = DIGIT_BAD;
                     else if (digits_c <= MAX_DIGITS) begin
                        if (acc_x10[67:64] != 4'd0) digits_in = DIGIT_BAD;
                        else begin
                           acc_in = acc_x10[63:0]; digits_in = digits_c + 5'd1;
                        end
                     end
                     if (gap || span >= POS_BITS'(10) || lc != ka_char(span[3:0]))
                        match_in = '0;
                     trim_in = 16'(span + 1'b1);
                  end
               end
            end
            PH_BODY: begin
               rem_in = rem_c - 64'd1;
               if (rem_in == 64'd0) begin
                  kind = SK_BODY; soff = 32'(start_c); slen = blen_c; phase_in = PH_DONE;
               end
            end
            default: ;
         endcase
      end
   end

   // result fields for this byte
   always_comb begin
      case (phase_in)
         PH_DONE: result.status = ST_DONE;
         PH_BAD:  result.status = ST_BAD;
         PH_MANY: result.status = ST_MANY;
         PH_TE:   result.status = ST_TE;
         default: result.status = ST_MORE;
      endcase
      result.slice_kind   = kind;
      result.slice_offset = soff;
      result.slice_length = slen;
      if (phase_in == PH_BODY || phase_in == PH_DONE) begin
         result.body_size    = blen_in;
         result.persist_conn = persist_in;
      end else begin
         result.body_size    = '0;
         result.persist_conn = 1'b0;
      end
   end

   // commit state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD; cr_ff <= 1'b0; pos_ff <= '0; start_ff <= '0;
         lines_ff <= '0; match_ff <= 5'h1f; nidx_ff <= '0; lead_ff <= 1'b1;
         trim_ff <= '0; acc_ff <= '0; digits_ff <= '0; vflags_ff <= '0;
         lseen_ff <= 1'b0; lerr_ff <= 1'b0; blen_ff <= '0; conn_ff <= 1'b0;
         persist_ff <= 1'b0; te_ff <= 1'b0; ver_ff <= '0; rem_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in; cr_ff <= cr_in; pos_ff <= pos_in; start_ff <= start_in;
         lines_ff <= lines_in; match_ff <= match_in; nidx_ff <= nidx_in; lead_ff <= lead_in;
         trim_ff <= trim_in; acc_ff <= acc_in; digits_ff <= digits_in;
         vflags_ff <= vflags_in; lseen_ff <= lseen_in; lerr_ff <= lerr_in;
         blen_ff <= blen_in; conn_ff <= conn_in; persist_ff <= persist_in;
         te_ff <= te_in; ver_ff <= ver_in; rem_ff <= rem_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/http_request_header_parser.sv =====
// Result: the status of a transfer is registered and shown in the next cycle.
// Throughput: one request byte per cycle; the result register frees up in the
// same cycle it is taken, so input stalls only while a result waits.
// Reset: synchronous, active high; clears parser state and the result valid flag,
// and loads the limits with their defaults. No clearing pass.
`default_nettype none
`include "assert_macros.svh"
module http_request_header_parser
   import hrp_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   hrp_req_if.sink   req_chan,
   hrp_rsp_if.source rsp_chan,
   hrp_csr_if.sink   csr_chan
);

   cfg_type    cfg_ff;
   result_type res_in, res_ff;
   logic       out_valid_ff;
   logic       take;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_limit  <= LIMIT_RESET;
         cfg_ff.field_limit <= LIMIT_RESET;
         cfg_ff.max_fields  <= FIELDS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_LINE_LIMIT:  cfg_ff.line_limit  <= csr_chan.data;
            REG_FIELD_LIMIT: cfg_ff.field_limit <= csr_chan.data;
            REG_MAX_FIELDS:  cfg_ff.max_fields  <= csr_chan.data[7:0];
            default: ;
         endcase
      end
   end

   hrp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (take),
      .data_byte   (req_chan.data_byte),
      .new_request (req_chan.new_request),
      .cfg         (cfg_ff),
      .result      (res_in)
   );

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (take) out_valid_ff <= 1'b1;
      else if (rsp_chan.ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take) res_ff <= res_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = res_ff.status;
   assign rsp_chan.slice_kind   = res_ff.slice_kind;
   assign rsp_chan.slice_offset = res_ff.slice_offset;
   assign rsp_chan.slice_length = res_ff.slice_length;
   assign rsp_chan.body_size    = res_ff.body_size;
   assign rsp_chan.persist_conn = res_ff.persist_conn;

   `ASSERT_CLK(a_take_gives_result, clock, reset, take |=> out_valid_ff)
   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !out_valid_ff)
   `ASSERT_CLK(a_no_slice_zero, clock, reset,
      (out_valid_ff && res_ff.slice_kind == SK_NONE) |->
         (res_ff.slice_offset == 32'd0 && res_ff.slice_length == 64'd0))
   `ASSERT_CLK(a_length_only_when_done, clock, reset,
      (out_valid_ff && (res_ff.status == ST_BAD || res_ff.status == ST_MANY ||
                        res_ff.status == ST_TE)) |->
         (res_ff.body_size == 64'd0 && !res_ff.persist_conn))

endmodule
`default_nettype wire
